[rtl/vpfa_pkg.sv]
// Package for the video payload frame assembler: field widths, header flag
// positions, limits and item codes. No dependencies.
package vpfa_pkg;

    localparam int PACKET_BYTES_MAX = 3072;
    localparam int OFFSET_BITS      = 24;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 12;
    localparam int FILL_W = 24;
    localparam int HDR_W  = 8;

    localparam logic [FILL_W-1:0] LIMIT_RESET = FILL_W'(42666);
    localparam logic [LEN_W-1:0]  POS_MAX     = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(PACKET_BYTES_MAX);
    localparam logic [LEN_W-1:0]  LEN_MIN     = LEN_W'(2);
    localparam logic [HDR_W-1:0]  HDR_MIN     = HDR_W'(2);

    // frame offsets wrap at OFFSET_BITS
    localparam logic [FILL_W-1:0] OFFSET_MASK =
        FILL_W'((64'd1 << OFFSET_BITS) - 64'd1);

    // bit positions in the flags byte (byte 1 of a packet)
    localparam int FLAG_ERROR_BIT = 6;
    localparam int FLAG_EOF_BIT   = 1;

    // item codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

endpackage

[rtl/video_payload_frame_assembler.sv]
// Video payload frame assembler, top level; depends on vpfa_pkg.
// Takes one packet byte per word and decides combinationally whether it is
// header, flags or frame payload. A word whose mode is start clears all frame
// state and gives no result. Byte 0 of a packet is the header length, byte 1
// the flags (bit 6 error, bit 1 end of frame); a packet is dropped on a
// transfer error in byte 0 or 1, the error flag, a length below 2 or above the
// packet maximum, or a header length below 2 or above the packet length.
// Payload bytes after the header leave with their frame offset while the frame
// holds fewer than frame_limit bytes; on the last byte of a packet the frame
// completes on overflow, or on end of frame with a non-empty frame, and later
// packets are ignored until the next start. Rate: one word per clock unless
// stalled; each accepted word's result is registered. All state lives in a few
// counters and flags updated in the accepting cycle, and the single result
// register decouples the two sides, so input is stalled only while a held
// result is itself stalled. frame_limit may be written only while idle.
module video_payload_frame_assembler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [vpfa_pkg::FILL_W-1:0]   i_cfg_data,
    // input words
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic [vpfa_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_first_of_packet,
    input  logic [vpfa_pkg::LEN_W-1:0]    i_packet_length,
    input  logic                          i_packet_error,
    // result words
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_payload_valid,
    output logic [vpfa_pkg::BYTE_W-1:0]   o_payload_byte,
    output logic [vpfa_pkg::FILL_W-1:0]   o_frame_offset,
    output logic                          o_frame_done,
    output logic [vpfa_pkg::FILL_W-1:0]   o_frame_length
);
    import vpfa_pkg::*;

    // configuration and frame state
    logic [FILL_W-1:0] r_frame_limit;
    logic              r_capture_done, n_capture_done;
    logic [FILL_W-1:0] r_frame_fill,   n_frame_fill;
    logic [LEN_W-1:0]  r_byte_pos,     n_byte_pos;
    logic [HDR_W-1:0]  r_header,       n_header;
    logic              r_skipped,      n_skipped;
    logic              r_eof,          n_eof;
    logic              r_overflow,     n_overflow;

    // result register
    logic              r_out_valid;
    logic              r_pay_valid;
    logic [BYTE_W-1:0] r_pay_byte;
    logic [FILL_W-1:0] r_offset;
    logic              r_done;
    logic [FILL_W-1:0] r_length;

    logic              in_acc;
    logic              out_free;
    logic [LEN_W-1:0]  pos;
    logic              pos_zero;
    logic [LEN_W:0]    pos_next;
    logic              pay_valid;
    logic              done;
    logic [FILL_W-1:0] offset;
    logic              has_result;

    // the result register frees up when empty or when its word is taken
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !out_free;
    assign in_acc   = i_valid && out_free;

    assign pos      = i_first_of_packet ? '0 : r_byte_pos;
    assign pos_zero = (pos == '0);
    assign pos_next = {1'b0, pos} + (LEN_W+1)'(1);

    always_comb begin
        // a new packet starts with fresh per-packet flags
        n_header       = pos_zero ? '0   : r_header;
        n_skipped      = pos_zero ? 1'b0 : r_skipped;
        n_eof          = pos_zero ? 1'b0 : r_eof;
        n_overflow     = pos_zero ? 1'b0 : r_overflow;
        n_capture_done = r_capture_done;
        n_frame_fill   = r_frame_fill;
        pay_valid      = 1'b0;
        done           = 1'b0;
        offset         = '0;

        if (!n_skipped) begin
            if (pos_zero) begin
                n_header = i_data_byte;
                if (r_capture_done || i_packet_error
                    || i_packet_length < LEN_MIN || i_packet_length > LEN_MAX
                    || i_data_byte < HDR_MIN
                    || LEN_W'(i_data_byte) > i_packet_length) begin
                    n_skipped = 1'b1;
                end
            end else if (pos == LEN_W'(1)) begin
                if (i_packet_error || i_data_byte[FLAG_ERROR_BIT]) begin
                    n_skipped = 1'b1;
                end
                n_eof = i_data_byte[FLAG_EOF_BIT];
            end else if (pos >= LEN_W'(n_header)) begin
                if (r_frame_fill < r_frame_limit) begin
                    pay_valid    = 1'b1;
                    offset       = r_frame_fill;
                    n_frame_fill = (r_frame_fill + FILL_W'(1)) & OFFSET_MASK;
                end else begin
                    n_overflow = 1'b1;
                end
            end
            // last byte of the packet: close it and judge the frame
            if (!n_skipped && pos_next >= {1'b0, i_packet_length}) begin
                if (n_overflow || (n_eof && n_frame_fill != '0)) begin
                    n_capture_done = 1'b1;
                    done           = 1'b1;
                end
                n_skipped = 1'b1;
            end
        end

        n_byte_pos = (pos < POS_MAX) ? pos_next[LEN_W-1:0] : POS_MAX;
    end

    assign has_result = (i_mode == MODE_BYTE) && (pay_valid || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit  <= LIMIT_RESET;
            r_capture_done <= 1'b0;
            r_frame_fill   <= '0;
            r_byte_pos     <= '0;
            r_header       <= '0;
            r_skipped      <= 1'b0;
            r_eof          <= 1'b0;
            r_overflow     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_limit <= i_cfg_data;
            end
            if (in_acc) begin
                case (i_mode)
                    MODE_START: begin
                        // drop everything gathered so far
                        r_capture_done <= 1'b0;
                        r_frame_fill   <= '0;
                        r_byte_pos     <= '0;
                        r_header       <= '0;
                        r_skipped      <= 1'b0;
                        r_eof          <= 1'b0;
                        r_overflow     <= 1'b0;
                    end
                    MODE_BYTE: begin
                        r_capture_done <= n_capture_done;
                        r_frame_fill   <= n_frame_fill;
                        r_byte_pos     <= n_byte_pos;
                        r_header       <= n_header;
                        r_skipped      <= n_skipped;
                        r_eof          <= n_eof;
                        r_overflow     <= n_overflow;
                    end
                    default: begin
                        r_capture_done <= r_capture_done;
                    end
                endcase
            end
            if (out_free) begin
                r_out_valid <= in_acc && has_result;
            end
        end
    end

    // result payload: load only with a fresh result
    always_ff @(posedge i_clk) begin
        if (in_acc && has_result) begin
            r_pay_valid <= pay_valid;
            r_pay_byte  <= pay_valid ? i_data_byte : '0;
            r_offset    <= offset & OFFSET_MASK;
            r_done      <= done;
            r_length    <= n_frame_fill;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_payload_valid = r_pay_valid;
    assign o_payload_byte  = r_pay_byte;
    assign o_frame_offset  = r_offset;
    assign o_frame_done    = r_done;
    assign o_frame_length  = r_length;

`ifndef SYNTHESIS
    // every result word carries a stored byte or a frame completion
    a_result_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_payload_valid || o_frame_done))
        else $error("result word with neither payload nor frame end");

    // completing a frame locks the capture
    a_done_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && has_result && done) |=> r_capture_done)
        else $error("frame completed but capture not marked done");

    // a stored byte always sits just below the reported frame length
    a_offset_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_payload_valid) |->
            (((o_frame_offset + FILL_W'(1)) & OFFSET_MASK) == o_frame_length))
        else $error("frame offset and length disagree");

    // no payload is stored once the capture is complete
    a_no_store_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == MODE_BYTE && r_capture_done) |-> !pay_valid)
        else $error("payload stored after capture completed");
`endif

endmodule
